// ----- rtl/core/ptk_pkg.sv -----
// Shared types and constants for the packet ack and retransmit tracker.
// No dependencies.
`default_nettype none
package ptk_pkg;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 104;
	localparam int CFG_W     = 9;

	localparam logic [29:0] NT_CAP  = 30'd1_000_000_000;
	localparam logic [30:0] RTT_MAX = '1;

	typedef enum logic [2:0] {
		ACT_SEND   = 3'd0,
		ACT_ACK    = 3'd1,
		ACT_TICK   = 3'd2,
		ACT_FAIL   = 3'd3,
		ACT_RSALL  = 3'd4,
		ACT_ACKALL = 3'd5,
		ACT_CANCEL = 3'd6
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_ACK,
		ST_RM0,
		ST_RM1,
		ST_RM2,
		ST_TICK,
		ST_FLAGS,
		ST_DONE
	} st_t;

endpackage
`default_nettype wire

// ----- rtl/core/ptk_time_mem.sv -----
// Per-packet flight time and dropped time memories, one shared read port,
// separate write enables, registered read data. No dependencies.
`default_nettype none
module ptk_time_mem #(
	parameter int DEPTH = 256,
	parameter int TW    = 32
) (
	input  wire                      clk,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire                      fl_we,
	input  wire  [TW-1:0]            fl_wdata,
	input  wire                      dr_we,
	input  wire  [TW-1:0]            dr_wdata,
	output logic [TW-1:0]            fl_rdata,
	output logic [TW-1:0]            dr_rdata
);

	logic [TW-1:0] fl_mem [DEPTH];
	logic [TW-1:0] dr_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[waddr] <= fl_wdata;
		end
		if (dr_we) begin
			dr_mem[waddr] <= dr_wdata;
		end
		fl_rdata <= fl_mem[raddr];
		dr_rdata <= dr_mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/ptk_stack_mem.sv -----
// Resend stack storage: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module ptk_stack_mem #(
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [$clog2(DEPTH)-1:0] wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [$clog2(DEPTH)-1:0] rdata
);

	logic [$clog2(DEPTH)-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/packet_ack_retransmit_tracker.sv -----
// Top level of the packet ack and retransmit tracker.
// Depends on ptk_pkg, ptk_time_mem and ptk_stack_mem.
`default_nettype none
// Takes one action word at a time and returns one result word per action.
// An ack also searches the resend stack when the packet must be taken out
// of it (one stack entry read per cycle). Tick walks the flight and dropped
// time memories one packet per cycle; resend all and ack all walk the flag
// vectors. A finished result waits in the output register while the next
// word is accepted.
module packet_ack_retransmit_tracker #(
	parameter int MAX_PACKETS = 256,
	parameter int TIME_BITS   = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [ptk_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// action
	input  wire  [2:0]                       s_tuser,
	// packet_index, delta_time, update_rtt, timeout_limit, window_below_one,
	// current_rtt
	input  wire  [ptk_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// packet_valid, send_index, canceled, success_count, send_failure_count,
	// timeout_count, rtt_valid, rtt_sample, next_timeout
	output logic [ptk_pkg::M_TDATA_W-1:0]    m_tdata
);

	import ptk_pkg::*;

	localparam int IW = $clog2(MAX_PACKETS);
	localparam int DW = $clog2(MAX_PACKETS + 1);
	localparam int EW = (DW > 9) ? DW : 9;
	localparam int WW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;
	localparam logic [DW-1:0] MAX_D  = DW'(MAX_PACKETS);
	localparam logic [DW-1:0] LAST_D = DW'(MAX_PACKETS - 1);
	localparam logic [EW-1:0] MAX_E  = EW'(MAX_PACKETS);
	localparam logic signed [WW-1:0] T_HI =
		{{(WW - TIME_BITS + 1){1'b0}}, {(TIME_BITS - 1){1'b1}}};
	localparam logic signed [WW-1:0] T_LO =
		{{(WW - TIME_BITS + 1){1'b1}}, {(TIME_BITS - 1){1'b0}}};
	localparam logic signed [WW-1:0] NT_CAP_W  = WW'(NT_CAP);
	localparam logic signed [WW-1:0] RTT_MAX_W = WW'(RTT_MAX);

	function automatic logic [TIME_BITS-1:0] tsat(input logic signed [WW-1:0] v);
		if (v > T_HI) begin
			return T_HI[TIME_BITS-1:0];
		end else if (v < T_LO) begin
			return T_LO[TIME_BITS-1:0];
		end
		return v[TIME_BITS-1:0];
	endfunction

	function automatic logic [30:0] rclamp(input logic signed [WW-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > RTT_MAX_W) begin
			return RTT_MAX;
		end
		return v[30:0];
	endfunction

	st_t st_q, st_d;

	act_t        act_q;
	logic [7:0]  idx_q;
	logic [30:0] delta_q;
	logic        upd_q;
	logic [30:0] limit_q;
	logic        wbelow_q;
	logic [30:0] crtt_q;

	logic [8:0]             pc_q;
	logic [MAX_PACKETS-1:0] infl_q, drop_q, ack_q;
	logic [DW-1:0]          depth_q, next_q;
	logic                   cancel_q;

	logic [DW-1:0] cnt_q;
	logic          v_s1;
	logic [IW-1:0] i_s1;
	logic [IW-1:0] top_q;

	logic                   pv_q, rv_q;
	logic [IW-1:0]          sidx_q;
	logic [DW-1:0]          succ_q, fail_q, tmo_q;
	logic [30:0]            rtt_q;
	logic signed [WW-1:0]   nt_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic                 stk_we;
	logic [IW-1:0]        stk_wa, stk_wd, stk_ra, stk_rdata;
	logic [IW-1:0]        tm_ra, tm_wa;
	logic                 fl_we, dr_we;
	logic [TIME_BITS-1:0] fl_wd, dr_wd, fl_rdata, dr_rdata;

	logic [EW-1:0]        eff;
	logic [IW-1:0]        idx_i;
	logic                 in_range, can_push, has_next, load;
	logic signed [WW-1:0] delta_w, limit_w, fl_w, dr_w, nf_w, rem_w;
	logic [TIME_BITS-1:0] launch_time, nf, nd_age;
	logic                 tk_infl, tk_to;
	logic [29:0]          nt_out;

	ptk_time_mem #(.DEPTH(MAX_PACKETS), .TW(TIME_BITS)) u_time (
		.clk      (clk),
		.raddr    (tm_ra),
		.waddr    (tm_wa),
		.fl_we    (fl_we),
		.fl_wdata (fl_wd),
		.dr_we    (dr_we),
		.dr_wdata (dr_wd),
		.fl_rdata (fl_rdata),
		.dr_rdata (dr_rdata)
	);

	ptk_stack_mem #(.DEPTH(MAX_PACKETS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_wa),
		.wdata (stk_wd),
		.raddr (stk_ra),
		.rdata (stk_rdata)
	);

	assign eff      = (EW'(pc_q) > MAX_E) ? MAX_E : EW'(pc_q);
	assign idx_i    = IW'(idx_q);
	assign in_range = EW'(idx_q) < eff;
	assign can_push = depth_q != MAX_D;
	assign has_next = EW'(next_q) < eff;

	assign delta_w     = WW'(delta_q);
	assign limit_w     = WW'(limit_q);
	assign launch_time = tsat(-delta_w);
	assign fl_w        = WW'($signed(fl_rdata));
	assign dr_w        = WW'($signed(dr_rdata));
	assign nf          = tsat(fl_w + delta_w);
	assign nd_age      = tsat(dr_w + delta_w);
	assign nf_w        = WW'($signed(nf));
	assign rem_w       = limit_w - nf_w;
	assign tk_infl     = v_s1 && infl_q[i_s1];
	assign tk_to       = tk_infl && (nf_w > limit_w);

	assign load     = (st_q == ST_DONE) && (!out_valid_q || m_tready);
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		if (act_q != ACT_TICK || nt_q < 0) begin
			nt_out = '0;
		end else if (nt_q > NT_CAP_W) begin
			nt_out = NT_CAP;
		end else begin
			nt_out = nt_q[29:0];
		end
	end

	always_comb begin
		st_d   = st_q;
		stk_we = 1'b0;
		stk_wa = IW'(depth_q);
		stk_wd = idx_i;
		stk_ra = '0;
		tm_ra  = '0;
		tm_wa  = IW'(next_q);
		fl_we  = 1'b0;
		dr_we  = 1'b0;
		fl_wd  = launch_time;
		dr_wd  = nd_age;
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				st_d = ST_DONE;
				case (act_q)
					ACT_SEND: begin
						if (!cancel_q) begin
							if (depth_q != '0) begin
								stk_ra = IW'(depth_q - 1'b1);
								st_d   = ST_POP;
							end else if (has_next) begin
								fl_we = 1'b1;
							end
						end
					end
					ACT_ACK: begin
						if (in_range) begin
							tm_ra = idx_i;
							st_d  = ST_ACK;
						end
					end
					ACT_TICK: st_d = ST_TICK;
					ACT_FAIL: begin
						stk_we = in_range && infl_q[idx_i] && can_push;
					end
					ACT_RSALL, ACT_ACKALL: st_d = ST_FLAGS;
					default: st_d = ST_DONE;
				endcase
			end
			ST_POP: begin
				fl_we = 1'b1;
				tm_wa = stk_rdata;
				st_d  = ST_DONE;
			end
			ST_ACK: begin
				st_d = infl_q[idx_i] ? ST_DONE : ST_RM0;
			end
			ST_RM0: begin
				if (depth_q == '0) begin
					st_d = ST_DONE;
				end else begin
					stk_ra = IW'(depth_q - 1'b1);
					st_d   = ST_RM1;
				end
			end
			ST_RM1: begin
				stk_ra = '0;
				st_d   = ST_RM2;
			end
			ST_RM2: begin
				if (stk_rdata == idx_i) begin
					stk_we = 1'b1;
					stk_wa = IW'(cnt_q);
					stk_wd = top_q;
					st_d   = ST_DONE;
				end else if (({1'b0, cnt_q} + 1'b1) >= {1'b0, depth_q}) begin
					st_d = ST_DONE;
				end else begin
					stk_ra = IW'(cnt_q + 1'b1);
				end
			end
			ST_TICK: begin
				tm_ra = IW'(cnt_q);
				tm_wa = i_s1;
				if (v_s1) begin
					fl_we  = tk_infl;
					fl_wd  = nf;
					dr_we  = drop_q[i_s1] || tk_to;
					dr_wd  = tk_to ? nf : nd_age;
					stk_we = tk_to && can_push;
					stk_wd = i_s1;
				end
				if (cnt_q == MAX_D && !v_s1) begin
					st_d = ST_DONE;
				end
			end
			ST_FLAGS: begin
				if (cnt_q == LAST_D) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pc_q        <= '0;
			infl_q      <= '0;
			drop_q      <= '0;
			ack_q       <= '0;
			depth_q     <= '0;
			next_q      <= '0;
			cancel_q    <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			v_s1 <= (st_q == ST_TICK) && (cnt_q != MAX_D);
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_EXEC: begin
					case (act_q)
						ACT_SEND: begin
							if (!cancel_q) begin
								if (depth_q != '0) begin
									depth_q <= depth_q - 1'b1;
								end else if (has_next) begin
									infl_q[IW'(next_q)] <= 1'b1;
									next_q <= next_q + 1'b1;
								end
							end
						end
						ACT_FAIL: begin
							if (in_range && infl_q[idx_i]) begin
								infl_q[idx_i] <= 1'b0;
								if (can_push) begin
									depth_q <= depth_q + 1'b1;
								end
							end
						end
						ACT_CANCEL: cancel_q <= 1'b1;
						default: ;
					endcase
				end
				ST_POP: infl_q[stk_rdata] <= 1'b1;
				ST_ACK: begin
					if (ack_q[idx_i] || !infl_q[idx_i]) begin
						drop_q[idx_i] <= 1'b0;
					end
					infl_q[idx_i] <= 1'b0;
					ack_q[idx_i]  <= 1'b1;
				end
				ST_RM2: begin
					if (stk_rdata == idx_i) begin
						depth_q <= depth_q - 1'b1;
					end
				end
				ST_TICK: begin
					if (tk_to) begin
						drop_q[i_s1] <= 1'b1;
						infl_q[i_s1] <= 1'b0;
						if (can_push) begin
							depth_q <= depth_q + 1'b1;
						end
					end
				end
				ST_FLAGS: begin
					if (act_q == ACT_ACKALL && infl_q[IW'(cnt_q)]) begin
						ack_q[IW'(cnt_q)]  <= 1'b1;
						infl_q[IW'(cnt_q)] <= 1'b0;
					end
					if (act_q == ACT_RSALL && cnt_q == LAST_D) begin
						infl_q  <= '0;
						drop_q  <= '0;
						ack_q   <= '0;
						depth_q <= '0;
						next_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					act_q    <= act_t'(s_tuser);
					idx_q    <= s_tdata[7:0];
					delta_q  <= s_tdata[38:8];
					upd_q    <= s_tdata[39];
					limit_q  <= s_tdata[70:40];
					wbelow_q <= s_tdata[71];
					crtt_q   <= s_tdata[102:72];
					pv_q     <= 1'b0;
					sidx_q   <= '0;
					succ_q   <= '0;
					fail_q   <= '0;
					tmo_q    <= '0;
					rv_q     <= 1'b0;
					rtt_q    <= '0;
				end
			end
			ST_EXEC: begin
				cnt_q <= '0;
				case (act_q)
					ACT_SEND: begin
						if (!cancel_q && depth_q == '0 && has_next) begin
							pv_q   <= 1'b1;
							sidx_q <= IW'(next_q);
						end
					end
					ACT_TICK: nt_q <= wbelow_q ? WW'(crtt_q) : NT_CAP_W;
					ACT_FAIL: begin
						if (in_range && infl_q[idx_i]) begin
							fail_q <= DW'(1);
						end
					end
					default: ;
				endcase
			end
			ST_POP: begin
				pv_q   <= 1'b1;
				sidx_q <= stk_rdata;
			end
			ST_ACK: begin
				if (!ack_q[idx_i]) begin
					if (infl_q[idx_i]) begin
						succ_q <= DW'(1);
						if (upd_q) begin
							rv_q  <= 1'b1;
							rtt_q <= rclamp(fl_w + delta_w);
						end
					end else if (drop_q[idx_i] && upd_q) begin
						rv_q  <= 1'b1;
						rtt_q <= rclamp(dr_w + delta_w);
					end
				end
			end
			ST_RM1: begin
				top_q <= stk_rdata;
				cnt_q <= '0;
			end
			ST_RM2: cnt_q <= cnt_q + 1'b1;
			ST_TICK: begin
				if (cnt_q != MAX_D) begin
					cnt_q <= cnt_q + 1'b1;
				end
				i_s1 <= IW'(cnt_q);
				if (tk_to) begin
					tmo_q <= tmo_q + 1'b1;
				end else if (tk_infl && rem_w < nt_q) begin
					nt_q <= rem_w;
				end
			end
			ST_FLAGS: begin
				cnt_q <= cnt_q + 1'b1;
				if (infl_q[IW'(cnt_q)]) begin
					if (act_q == ACT_RSALL) begin
						fail_q <= fail_q + 1'b1;
					end else begin
						succ_q <= succ_q + 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (load) begin
					out_data_q <= {5'd0, nt_out, rtt_q, rv_q, 9'(tmo_q), 9'(fail_q),
						9'(succ_q), cancel_q, 8'(sidx_q), pv_q};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
